### src/bss_pkg.sv
// Package for the block SSIM engine: shared constants and register indexes.
// No dependencies.
package bss_pkg;

    localparam int MAX_BLOCK_SIDE = 16;
    localparam int MAX_BLOCKS     = 65536;

    localparam int MUL_W = 44;   // operand width of the serial multiplier
    localparam int ACC_W = 88;   // product width
    localparam int DVD_W = 102;  // dividend width
    localparam int DSR_W = 86;   // divisor width

    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] CFG_C1         = 2'd1;
    localparam logic [1:0] CFG_C2         = 2'd2;

    // product steps of the sequencer
    localparam logic [3:0] OP_SXSY = 4'd0;
    localparam logic [3:0] OP_SX2  = 4'd1;
    localparam logic [3:0] OP_SY2  = 4'd2;
    localparam logic [3:0] OP_M2   = 4'd3;
    localparam logic [3:0] OP_C1M  = 4'd4;
    localparam logic [3:0] OP_C2M  = 4'd5;
    localparam logic [3:0] OP_MSXY = 4'd6;
    localparam logic [3:0] OP_MSS  = 4'd7;
    localparam logic [3:0] OP_DEN  = 4'd8;
    localparam logic [3:0] OP_PROD = 4'd9;

endpackage

### src/block_ssim_engine.sv
// Block SSIM engine: per-block SSIM and image mean in signed Q1.15.
// Depends on bss_pkg.
//
// A pixel pair that closes no block and ends no image leaves ready high. A pixel
// pair that closes a block holds ready low while the block is processed: ten
// multiplier passes (load, 44 shift-add steps, store), a state for the ratio terms,
// a 102-step restoring divider, and states that form and post the result; a zero
// denominator skips the DEN and PROD passes and the divider. An image end adds
// the mean (setup, 102 divider steps, post). A stalled output register adds its stall.
// rst_n (async, active low) clears the pixel and mean sums and loads register defaults.
module block_ssim_engine
    import bss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] ref_pixel, [15:8] cmp_pixel
    input  logic        s_tlast,   // image_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] ssim_value
    output logic [0:0]  m_tuser,   // [0] is_mean
    output logic        m_tlast,   // last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_MLOAD, S_MRUN, S_MSTORE, S_CALC, S_DIV, S_BRES, S_BOUT, S_MSET, S_MOUT
    } state_t;

    state_t state_reg;

    logic [4:0]  block_size_reg;
    logic [15:0] c1_reg, c2_reg;

    logic [15:0] ref_sum_reg, cmp_sum_reg;
    logic [23:0] ref_sq_reg, cmp_sq_reg, cross_reg;
    logic [8:0]  count_reg;
    logic signed [33:0] total_reg;
    logic [16:0] bcount_reg;

    // block snapshot
    logic [15:0] w_sx_reg, w_sy_reg;
    logic [24:0] w_ss_reg;
    logic [23:0] w_sxy_reg;
    logic [8:0]  w_m_reg;
    logic        end_reg;

    // intermediate products
    logic [31:0] sxsy_reg, sx2_reg;
    logic [32:0] sq_reg, c1m_reg, c2m_reg, msxy_reg;
    logic [33:0] mss_reg;
    logic [16:0] m2_reg;
    logic [41:0] a_reg, ad_reg, bd_reg;
    logic [42:0] bmag_reg;
    logic        bneg_reg;
    logic [83:0] den_reg;

    // shared multiplier
    logic [3:0]       op_reg;
    logic [ACC_W-1:0] mx_reg, acc_reg;
    logic [MUL_W-1:0] my_reg;
    logic [5:0]       mcnt_reg;

    // shared divider
    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg, rem_reg;
    logic [16:0]      q_reg;
    logic             qovf_reg;
    logic [6:0]       dcnt_reg;
    logic             dmean_reg;
    logic             mneg_reg;

    logic [15:0] res_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_mean_reg, out_last_reg;

    // ---------------- combinational helpers
    logic [4:0]  side;
    logic [8:0]  thr;
    logic [7:0]  px, py;
    logic [15:0] ref_sum_n, cmp_sum_n;
    logic [23:0] ref_sq_n, cmp_sq_n, cross_n;
    logic [8:0]  count_n;
    logic        take, complete, out_free, out_load;

    always_comb
    begin
        side = block_size_reg;
        if (side < 5'd2)
            side = 5'd2;
        if (side > 5'(MAX_BLOCK_SIDE))
            side = 5'(MAX_BLOCK_SIDE);
    end

    assign thr       = 9'(side) * 9'(side);
    assign px        = s_tdata[7:0];
    assign py        = s_tdata[15:8];
    assign ref_sum_n = ref_sum_reg + 16'(px);
    assign cmp_sum_n = cmp_sum_reg + 16'(py);
    assign ref_sq_n  = ref_sq_reg + 24'(px) * 24'(px);
    assign cmp_sq_n  = cmp_sq_reg + 24'(py) * 24'(py);
    assign cross_n   = cross_reg + 24'(px) * 24'(py);
    assign count_n   = count_reg + 9'd1;
    assign complete  = count_n >= thr;
    assign take      = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = out_free && (state_reg == S_BOUT || state_reg == S_MOUT);

    // terms of the SSIM ratio
    logic signed [34:0] cov;
    logic signed [43:0] bn;
    assign cov = $signed({2'b00, msxy_reg}) - $signed({3'b000, sxsy_reg});
    assign bn  = (44'(cov) <<< 9) + $signed({11'd0, c2m_reg});

    // divider step
    logic [DSR_W:0]   rem_sh;
    logic             dfit;
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign dfit   = rem_sh >= {1'b0, dsr_reg};

    // block result from quotient
    logic [16:0] mag;
    assign mag = (qovf_reg || q_reg > 17'd32768) ? 17'd32768 : q_reg;

    logic [33:0] tmag;
    assign tmag = total_reg[33] ? 34'(-total_reg) : 34'(total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            block_size_reg <= 5'd8;
            c1_reg         <= 16'd1665;
            c2_reg         <= 16'd14982;
            ref_sum_reg    <= '0;
            cmp_sum_reg    <= '0;
            ref_sq_reg     <= '0;
            cmp_sq_reg     <= '0;
            cross_reg      <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            bcount_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_mean_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
            op_reg         <= OP_SXSY;
            mcnt_reg       <= '0;
            dcnt_reg       <= '0;
            dmean_reg      <= 1'b0;
            end_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BLOCK_SIZE: block_size_reg <= cfg_wdata[4:0];
                    CFG_C1:         c1_reg <= cfg_wdata;
                    CFG_C2:         c2_reg <= cfg_wdata;
                    default:        ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        end_reg   <= s_tlast;
                        w_sx_reg  <= ref_sum_n;
                        w_sy_reg  <= cmp_sum_n;
                        w_ss_reg  <= 25'(ref_sq_n) + 25'(cmp_sq_n);
                        w_sxy_reg <= cross_n;
                        w_m_reg   <= count_n;
                        if (complete || s_tlast)
                        begin
                            ref_sum_reg <= '0;
                            cmp_sum_reg <= '0;
                            ref_sq_reg  <= '0;
                            cmp_sq_reg  <= '0;
                            cross_reg   <= '0;
                            count_reg   <= '0;
                        end
                        else
                        begin
                            ref_sum_reg <= ref_sum_n;
                            cmp_sum_reg <= cmp_sum_n;
                            ref_sq_reg  <= ref_sq_n;
                            cmp_sq_reg  <= cmp_sq_n;
                            cross_reg   <= cross_n;
                            count_reg   <= count_n;
                        end
                        if (complete)
                        begin
                            op_reg    <= OP_SXSY;
                            state_reg <= S_MLOAD;
                        end
                        else if (s_tlast)
                            state_reg <= S_MSET;
                    end
                end

                S_MLOAD:
                begin
                    acc_reg  <= '0;
                    mcnt_reg <= '0;
                    case (op_reg)
                        OP_SXSY: begin mx_reg <= ACC_W'(w_sx_reg); my_reg <= MUL_W'(w_sy_reg); end
                        OP_SX2:  begin mx_reg <= ACC_W'(w_sx_reg); my_reg <= MUL_W'(w_sx_reg); end
                        OP_SY2:  begin mx_reg <= ACC_W'(w_sy_reg); my_reg <= MUL_W'(w_sy_reg); end
                        OP_M2:   begin mx_reg <= ACC_W'(w_m_reg);  my_reg <= MUL_W'(w_m_reg);  end
                        OP_C1M:  begin mx_reg <= ACC_W'(c1_reg);   my_reg <= MUL_W'(m2_reg);   end
                        OP_C2M:  begin mx_reg <= ACC_W'(c2_reg);   my_reg <= MUL_W'(m2_reg);   end
                        OP_MSXY: begin mx_reg <= ACC_W'(w_m_reg);  my_reg <= MUL_W'(w_sxy_reg); end
                        OP_MSS:  begin mx_reg <= ACC_W'(w_m_reg);  my_reg <= MUL_W'(w_ss_reg); end
                        OP_DEN:  begin mx_reg <= ACC_W'(ad_reg);   my_reg <= MUL_W'(bd_reg);   end
                        default: begin mx_reg <= ACC_W'(a_reg);    my_reg <= MUL_W'(bmag_reg); end
                    endcase
                    state_reg <= S_MRUN;
                end

                S_MRUN:
                begin
                    if (my_reg[0])
                        acc_reg <= acc_reg + mx_reg;
                    mx_reg   <= mx_reg << 1;
                    my_reg   <= my_reg >> 1;
                    mcnt_reg <= mcnt_reg + 6'd1;
                    if (mcnt_reg == 6'(MUL_W - 1))
                        state_reg <= S_MSTORE;
                end

                S_MSTORE:
                begin
                    op_reg    <= op_reg + 4'd1;
                    state_reg <= S_MLOAD;
                    case (op_reg)
                        OP_SXSY: sxsy_reg <= acc_reg[31:0];
                        OP_SX2:  sx2_reg  <= acc_reg[31:0];
                        OP_SY2:  sq_reg   <= 33'(sx2_reg) + 33'(acc_reg[31:0]);
                        OP_M2:   m2_reg   <= acc_reg[16:0];
                        OP_C1M:  c1m_reg  <= acc_reg[32:0];
                        OP_C2M:  c2m_reg  <= acc_reg[32:0];
                        OP_MSXY: msxy_reg <= acc_reg[32:0];
                        OP_MSS:
                        begin
                            mss_reg   <= acc_reg[33:0];
                            state_reg <= S_CALC;
                        end
                        OP_DEN:  den_reg  <= acc_reg[83:0];
                        default:
                        begin
                            // dividend = prod*2^16 + den, divisor = 2*den
                            dvd_reg   <= DVD_W'({acc_reg[84:0], 16'd0}) + DVD_W'(den_reg);
                            dsr_reg   <= DSR_W'({den_reg, 1'b0});
                            rem_reg   <= '0;
                            q_reg     <= '0;
                            qovf_reg  <= 1'b0;
                            dcnt_reg  <= '0;
                            dmean_reg <= 1'b0;
                            state_reg <= S_DIV;
                        end
                    endcase
                end

                S_CALC:
                begin
                    a_reg    <= 42'({sxsy_reg, 9'd0}) + 42'(c1m_reg);
                    ad_reg   <= 42'({sq_reg, 8'd0}) + 42'(c1m_reg);
                    bd_reg   <= 42'({(mss_reg - 34'(sq_reg)), 8'd0}) + 42'(c2m_reg);
                    bneg_reg <= bn[43];
                    bmag_reg <= bn[43] ? 43'(-bn) : 43'(bn);
                    if (42'({sq_reg, 8'd0}) + 42'(c1m_reg) == '0 ||
                        42'({(mss_reg - 34'(sq_reg)), 8'd0}) + 42'(c2m_reg) == '0)
                    begin
                        res_reg   <= 16'sd32767;
                        state_reg <= S_BOUT;
                    end
                    else
                        state_reg <= S_MLOAD;
                end

                S_DIV:
                begin
                    dvd_reg  <= dvd_reg << 1;
                    rem_reg  <= dfit ? DSR_W'(rem_sh - {1'b0, dsr_reg}) : DSR_W'(rem_sh);
                    q_reg    <= {q_reg[15:0], dfit};
                    qovf_reg <= qovf_reg | q_reg[16];
                    dcnt_reg <= dcnt_reg + 7'd1;
                    if (dcnt_reg == 7'(DVD_W - 1))
                        state_reg <= dmean_reg ? S_MOUT : S_BRES;
                end

                S_BRES:
                begin
                    if (bneg_reg)
                        res_reg <= 16'(-mag);
                    else
                        res_reg <= (mag > 17'd32767) ? 16'd32767 : mag[15:0];
                    state_reg <= S_BOUT;
                end

                S_BOUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= res_reg;
                        out_mean_reg  <= 1'b0;
                        out_last_reg  <= !end_reg;
                        if (bcount_reg < 17'(MAX_BLOCKS))
                        begin
                            total_reg  <= total_reg + 34'($signed(res_reg));
                            bcount_reg <= bcount_reg + 17'd1;
                        end
                        state_reg <= end_reg ? S_MSET : S_IDLE;
                    end
                end

                S_MSET:
                begin
                    mneg_reg <= total_reg[33];
                    if (bcount_reg == '0)
                    begin
                        q_reg     <= '0;
                        state_reg <= S_MOUT;
                    end
                    else
                    begin
                        // round half away from zero: (2|t| + n) / 2n
                        dvd_reg   <= DVD_W'({tmag, 1'b0}) + DVD_W'(bcount_reg);
                        dsr_reg   <= DSR_W'({bcount_reg, 1'b0});
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        qovf_reg  <= 1'b0;
                        dcnt_reg  <= '0;
                        dmean_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                end

                S_MOUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= mneg_reg ? 16'(-q_reg) : q_reg[15:0];
                        out_mean_reg  <= 1'b1;
                        out_last_reg  <= 1'b1;
                        total_reg     <= '0;
                        bcount_reg    <= '0;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_mean_reg;
    assign m_tlast    = out_last_reg;

endmodule

### src/bss_checker.sv
// Port-level checks for block_ssim_engine, bound into block_ssim_engine.
// Depends on block_ssim_engine ports only.
module bss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // the image mean always closes the results of its image
    a_mean_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("mean without last");

    // an image end transfer drops ready for the mean sequence
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("ready after image end transfer");

endmodule

bind block_ssim_engine bss_checker u_bss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
